/* rtl/core/repeated_reply_packet_sender_top_defines.svh */
// Assertion macros for the repeated reply packet sender
`ifndef REPEATED_REPLY_PACKET_SENDER_TOP_DEFINES_SVH
`define REPEATED_REPLY_PACKET_SENDER_TOP_DEFINES_SVH

// clocked assertion, off while in reset
`define RRPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion, also checked through reset
`define RRPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rrps_pkg.sv */
// Shared types and constants for the repeated reply packet sender
`timescale 1ns / 1ps
package rrps_pkg;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_POWER  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] REG_POWER_DELAY  = 2'd0;
  localparam logic [1:0] REG_POWER_CYCLES = 2'd1;
  localparam logic [1:0] REG_STATUS_DELAY = 2'd2;
  localparam logic [1:0] REG_STATUS_CYCLES = 2'd3;

  localparam logic [7:0] RST_POWER_DELAY   = 8'd50;
  localparam logic [7:0] RST_POWER_CYCLES  = 8'd7;
  localparam logic [7:0] RST_STATUS_DELAY  = 8'd5;
  localparam logic [7:0] RST_STATUS_CYCLES = 8'd3;

  localparam logic [7:0] FRAME_HEAD = 8'hFD;
  localparam logic [7:0] FRAME_TAIL = 8'hFE;
  localparam logic [7:0] POWER_CMD  = 8'h01;
  localparam logic [7:0] FRAME_PAD  = 8'h00;

  localparam logic [2:0] BYTE_HEAD = 3'd0;
  localparam logic [2:0] BYTE_CMD  = 3'd1;
  localparam logic [2:0] BYTE_PAD  = 3'd2;
  localparam logic [2:0] BYTE_A    = 3'd3;
  localparam logic [2:0] BYTE_B    = 3'd4;
  localparam logic [2:0] BYTE_TAIL = 3'd5;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } frame_job_t;

  typedef struct packed {
    logic       valid;
    frame_job_t job;
  } job_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

/* rtl/core/rrps_queue.sv */
// Small register queue of frame jobs between front and back
`timescale 1ns / 1ps
module rrps_queue import rrps_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  job_push_t   push,
  input  logic        pop,
  output frame_job_t  head,
  output queue_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  frame_job_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign do_push   = push.valid && !stat.full;
  assign do_pop    = pop && !stat.empty;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

/* rtl/core/rrps_front.sv */
// Front end: configuration, reply mode state and tick handling
`timescale 1ns / 1ps
module rrps_front import rrps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        accept,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_status_command,
  input  logic [7:0]  in_status_value,
  input  logic [7:0]  in_dimmer_duty,
  output job_push_t   push
);

  logic [7:0] power_delay_r, power_cycles_r, status_delay_r, status_cycles_r;
  logic       power_active_r, power_active_nxt;
  logic       status_active_r, status_active_nxt;
  logic       send_pending_r, send_pending_nxt;
  logic [7:0] delay_count_r, delay_count_nxt;
  logic [7:0] cycle_count_r, cycle_count_nxt;

  logic [7:0] sel_ticks, sel_cycles;
  logic [8:0] delay_inc, cycle_inc;
  logic       delay_hit, cycle_hit;

  assign sel_ticks  = power_active_r ? power_delay_r  : status_delay_r;
  assign sel_cycles = power_active_r ? power_cycles_r : status_cycles_r;
  assign delay_inc  = {1'b0, delay_count_r} + 9'd1;
  assign cycle_inc  = {1'b0, cycle_count_r} + 9'd1;
  assign delay_hit  = (delay_inc >= {1'b0, sel_ticks});
  assign cycle_hit  = (cycle_inc >= {1'b0, sel_cycles});

  always_comb begin
    power_active_nxt  = power_active_r;
    status_active_nxt = status_active_r;
    send_pending_nxt  = send_pending_r;
    delay_count_nxt   = delay_count_r;
    cycle_count_nxt   = cycle_count_r;
    push              = '0;
    if (accept) begin
      unique case (in_kind)
        KIND_POWER: begin
          power_active_nxt = 1'b1;
          send_pending_nxt = 1'b1;
        end
        KIND_STATUS: begin
          status_active_nxt = 1'b1;
          send_pending_nxt  = 1'b1;
        end
        KIND_TICK: begin
          if (power_active_r || status_active_r) begin
            if (send_pending_r) begin
              send_pending_nxt = 1'b0;
              push.valid       = 1'b1;
              if (power_active_r) begin
                push.job = '{cmd: POWER_CMD, byte_a: FRAME_PAD, byte_b: FRAME_PAD};
              end else begin
                push.job = '{cmd: in_status_command, byte_a: in_status_value,
                             byte_b: in_dimmer_duty};
              end
            end else if (delay_hit) begin
              delay_count_nxt  = '0;
              send_pending_nxt = 1'b1;
              if (cycle_hit) begin
                cycle_count_nxt = '0;
                if (power_active_r) begin
                  power_active_nxt = 1'b0;
                end else begin
                  status_active_nxt = 1'b0;
                end
              end else begin
                cycle_count_nxt = cycle_inc[7:0];
              end
            end else begin
              delay_count_nxt = delay_inc[7:0];
            end
          end else begin
            delay_count_nxt = '0;
            cycle_count_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_delay_r   <= RST_POWER_DELAY;
      power_cycles_r  <= RST_POWER_CYCLES;
      status_delay_r  <= RST_STATUS_DELAY;
      status_cycles_r <= RST_STATUS_CYCLES;
      power_active_r  <= 1'b0;
      status_active_r <= 1'b0;
      send_pending_r  <= 1'b0;
      delay_count_r   <= '0;
      cycle_count_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POWER_DELAY:   power_delay_r   <= cfg_wdata;
          REG_POWER_CYCLES:  power_cycles_r  <= cfg_wdata;
          REG_STATUS_DELAY:  status_delay_r  <= cfg_wdata;
          REG_STATUS_CYCLES: status_cycles_r <= cfg_wdata;
          default: ;
        endcase
      end
      power_active_r  <= power_active_nxt;
      status_active_r <= status_active_nxt;
      send_pending_r  <= send_pending_nxt;
      delay_count_r   <= delay_count_nxt;
      cycle_count_r   <= cycle_count_nxt;
    end
  end

endmodule

/* rtl/core/rrps_back.sv */
// Back end: serialises queued frame jobs into output bytes
`timescale 1ns / 1ps
module rrps_back import rrps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_job_t  head,
  input  queue_stat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte
);

  frame_job_t job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       advance;
  logic [7:0] cur_byte;

  assign advance       = !valid_r || out_ready;
  assign pop           = !busy_r && !stat.empty;
  assign out_valid     = valid_r;
  assign out_tx_byte   = byte_r;
  assign out_last_byte = last_r;

  always_comb begin
    unique case (idx_r)
      BYTE_HEAD: cur_byte = FRAME_HEAD;
      BYTE_CMD:  cur_byte = job_r.cmd;
      BYTE_PAD:  cur_byte = FRAME_PAD;
      BYTE_A:    cur_byte = job_r.byte_a;
      BYTE_B:    cur_byte = job_r.byte_b;
      BYTE_TAIL: cur_byte = FRAME_TAIL;
      default:   cur_byte = FRAME_PAD;
    endcase
  end

  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (pop) begin
      job_nxt  = head;
      busy_nxt = 1'b1;
      idx_nxt  = BYTE_HEAD;
    end
    if (advance) begin
      valid_nxt = busy_r;
      if (busy_r) begin
        byte_nxt = cur_byte;
        last_nxt = (idx_r == BYTE_TAIL);
        idx_nxt  = idx_r + 3'd1;
        if (idx_r == BYTE_TAIL) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= BYTE_HEAD;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

/* rtl/core/repeated_reply_packet_sender_top.sv */
// Top level of the repeated reply packet sender
`timescale 1ns / 1ps
// Takes one request per cycle while the frame queue has room: arm requests and
// ticks that only count take effect in the cycle they are accepted. A tick with
// a send pending queues one six-byte frame (FD, command, 00, A, B, FE); the
// byte serialiser behind the queue loads a frame and then sends one byte per
// cycle while out_ready is high. QUEUE_DEPTH frames may wait between the two
// sides; in_ready drops only while the queue is full. Configuration writes land
// immediately.
module repeated_reply_packet_sender_top import rrps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_status_command,
  input  logic [7:0] in_status_value,
  input  logic [7:0] in_dimmer_duty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  job_push_t   push;
  frame_job_t  head;
  queue_stat_t stat;
  logic        pop;

  assign in_ready = !stat.full;

  rrps_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .accept            (in_valid && in_ready),
    .in_kind           (in_kind),
    .in_status_command (in_status_command),
    .in_status_value   (in_status_value),
    .in_dimmer_duty    (in_dimmer_duty),
    .push              (push)
  );

  rrps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  rrps_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

/* rtl/core/rrps_checker.sv */
// Port-level checker for the repeated reply packet sender, with its bind
`timescale 1ns / 1ps
`include "repeated_reply_packet_sender_top_defines.svh"
module rrps_checker import rrps_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last_byte
);

  logic [2:0] pos_r, pos_nxt;

  // position of the next request within its frame
  always_comb begin
    pos_nxt = pos_r;
    if (out_valid && out_ready) begin
      pos_nxt = (pos_r == BYTE_TAIL) ? BYTE_HEAD : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= BYTE_HEAD;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  `RRPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_last_byte), "output request changed while stalled")
  `RRPS_ASSERT(a_last_pos, out_valid |-> (out_last_byte == (pos_r == BYTE_TAIL)), "last byte flag out of frame position")
  `RRPS_ASSERT(a_head_byte, out_valid && pos_r == BYTE_HEAD |-> out_tx_byte == FRAME_HEAD, "frame does not open with head byte")
  `RRPS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "output valid straight after reset")

endmodule

bind repeated_reply_packet_sender_top rrps_checker u_rrps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_tx_byte   (out_tx_byte),
  .out_last_byte (out_last_byte)
);
